// ===== hw/rtl/sll_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sll_pkg
// Shared types, codes and the control store for the linked list table:
// operation and status codes, micro-op and jump codes, and the microprogram.
// ----------------------------------------------------------------------------
package sll_pkg;

    // stream field widths
    localparam int OP_W       = 2;
    localparam int NODE_W     = 6;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT    = 2'd0;
    localparam logic [OP_W-1:0] OP_TAKE_IDX  = 2'd1;
    localparam logic [OP_W-1:0] OP_TAKE_TAIL = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY_BAD = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // micro-ops executed by the datapath
    typedef enum logic [4:0] {
        U_NONE,
        U_IDLE,
        U_START,
        U_WALK,
        U_PICK,
        U_HIT,
        U_ALLOC,
        U_POP,
        U_APPEND,
        U_SETHEAD,
        U_RDVIC,
        U_UNLINK,
        U_RELEASE,
        U_RES_OK,
        U_RES_FULL,
        U_RES_BAD,
        U_RES_NF,
        U_EMIT
    } t_uop;

    // jump conditions; C_NEXT never jumps
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_REQ,
        C_OP_INS,
        C_OP_NOTAKE,
        C_BAD,
        C_HEAD_HIT,
        C_MORE,
        C_NOT_FOUND,
        C_FULL,
        C_HEAD_ZERO,
        C_OUT_BUSY
    } t_cond;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] t_pc;

    // control word
    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic req;
        logic op_ins;
        logic op_notake;
        logic bad;
        logic head_hit;
        logic more;
        logic not_found;
        logic full;
        logic head_zero;
        logic out_busy;
    } t_flags;

    // program entry points
    localparam t_pc P_IDLE  = 5'd0;
    localparam t_pc P_TAKE  = 5'd4;
    localparam t_pc P_TWALK = 5'd5;
    localparam t_pc P_HIT   = 5'd8;
    localparam t_pc P_RM    = 5'd9;
    localparam t_pc P_INS   = 5'd12;
    localparam t_pc P_IWALK = 5'd15;
    localparam t_pc P_SETH  = 5'd17;
    localparam t_pc P_OK    = 5'd18;
    localparam t_pc P_FULL  = 5'd19;
    localparam t_pc P_BAD   = 5'd20;
    localparam t_pc P_NF    = 5'd21;
    localparam t_pc P_EMIT  = 5'd22;

    function automatic t_ctrl sll_cw(input t_uop uop, input t_cond cond, input t_pc target);
        t_ctrl cw;
        cw.uop    = uop;
        cw.cond   = cond;
        cw.target = target;
        return cw;
    endfunction

    // microprogram
    function automatic t_ctrl sll_ucode(input t_pc pc);
        t_ctrl cw;
        case (pc)
            // dispatch
            5'd0:  cw = sll_cw(U_IDLE,     C_NO_REQ,    P_IDLE);
            5'd1:  cw = sll_cw(U_NONE,     C_OP_INS,    P_INS);
            5'd2:  cw = sll_cw(U_NONE,     C_OP_NOTAKE, P_OK);
            5'd3:  cw = sll_cw(U_NONE,     C_BAD,       P_BAD);
            // take: walk the used chain
            5'd4:  cw = sll_cw(U_START,    C_HEAD_HIT,  P_HIT);
            5'd5:  cw = sll_cw(U_WALK,     C_MORE,      P_TWALK);
            5'd6:  cw = sll_cw(U_NONE,     C_NOT_FOUND, P_NF);
            5'd7:  cw = sll_cw(U_PICK,     C_ALWAYS,    P_RM);
            5'd8:  cw = sll_cw(U_HIT,      C_NEXT,      P_IDLE);
            // take: unlink and free the entry
            5'd9:  cw = sll_cw(U_RDVIC,    C_NEXT,      P_IDLE);
            5'd10: cw = sll_cw(U_UNLINK,   C_NEXT,      P_IDLE);
            5'd11: cw = sll_cw(U_RELEASE,  C_ALWAYS,    P_EMIT);
            // insert
            5'd12: cw = sll_cw(U_ALLOC,    C_FULL,      P_FULL);
            5'd13: cw = sll_cw(U_POP,      C_NEXT,      P_IDLE);
            5'd14: cw = sll_cw(U_START,    C_HEAD_ZERO, P_SETH);
            5'd15: cw = sll_cw(U_WALK,     C_MORE,      P_IWALK);
            5'd16: cw = sll_cw(U_APPEND,   C_ALWAYS,    P_OK);
            5'd17: cw = sll_cw(U_SETHEAD,  C_NEXT,      P_IDLE);
            // results
            5'd18: cw = sll_cw(U_RES_OK,   C_ALWAYS,    P_EMIT);
            5'd19: cw = sll_cw(U_RES_FULL, C_ALWAYS,    P_EMIT);
            5'd20: cw = sll_cw(U_RES_BAD,  C_ALWAYS,    P_EMIT);
            5'd21: cw = sll_cw(U_RES_NF,   C_NEXT,      P_IDLE);
            5'd22: cw = sll_cw(U_EMIT,     C_OUT_BUSY,  P_EMIT);
            5'd23: cw = sll_cw(U_NONE,     C_ALWAYS,    P_IDLE);
            default: cw = sll_cw(U_NONE,   C_ALWAYS,    P_IDLE);
        endcase
        return cw;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sll_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sll_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/sll_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sll_seq
// Microsequencer: step counter, control store lookup and conditional jumps.
// ----------------------------------------------------------------------------
module sll_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sll_pkg::t_flags i_flags,
    output sll_pkg::t_ctrl       o_ctrl
);

    sll_pkg::t_pc   r_pc;
    sll_pkg::t_pc   n_pc;
    sll_pkg::t_ctrl w_cw;
    logic           w_jump;

    // control store lookup
    assign w_cw   = sll_pkg::sll_ucode(r_pc);
    assign o_ctrl = w_cw;

    // jump condition select
    always_comb begin
        unique case (w_cw.cond)
            sll_pkg::C_NEXT:      w_jump = 1'b0;
            sll_pkg::C_ALWAYS:    w_jump = 1'b1;
            sll_pkg::C_NO_REQ:    w_jump = !i_flags.req;
            sll_pkg::C_OP_INS:    w_jump = i_flags.op_ins;
            sll_pkg::C_OP_NOTAKE: w_jump = i_flags.op_notake;
            sll_pkg::C_BAD:       w_jump = i_flags.bad;
            sll_pkg::C_HEAD_HIT:  w_jump = i_flags.head_hit;
            sll_pkg::C_MORE:      w_jump = i_flags.more;
            sll_pkg::C_NOT_FOUND: w_jump = i_flags.not_found;
            sll_pkg::C_FULL:      w_jump = i_flags.full;
            sll_pkg::C_HEAD_ZERO: w_jump = i_flags.head_zero;
            sll_pkg::C_OUT_BUSY:  w_jump = i_flags.out_busy;
            default:              w_jump = 1'b0;
        endcase
    end

    // next step
    assign n_pc = w_jump ? w_cw.target : sll_pkg::t_pc'(r_pc + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= sll_pkg::P_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/sll_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sll_dpath
// Datapath: chain heads, fresh-entry count, walk registers, link and data
// RAMs, and the output register, all driven by the current micro-op.
// ----------------------------------------------------------------------------
module sll_dpath #(
    parameter int ENTRIES    = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire sll_pkg::t_ctrl                  i_ctrl,
    output sll_pkg::t_flags                      o_flags,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [sll_pkg::OP_W-1:0]        i_op,
    input  wire logic [sll_pkg::NODE_W-1:0]      i_node,
    input  wire logic [sll_pkg::VALUE_W-1:0]     i_value,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [sll_pkg::STATUS_W-1:0]    o_status,
    output logic      [sll_pkg::M_TDATA_W-1:0]   o_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam int FW = $clog2(ENTRIES + 1);

    // control state
    logic [IW-1:0] r_free_head;
    logic [IW-1:0] r_used_head;
    logic [FW-1:0] r_fill;
    logic          r_out_valid;

    // request and walk registers
    logic [sll_pkg::OP_W-1:0]   r_op;
    logic [sll_pkg::NODE_W-1:0] r_node_raw;
    logic [DATA_WIDTH-1:0]      r_value;
    logic                       r_tail_mode;
    logic [IW-1:0]              r_cur;
    logic [IW-1:0]              r_pred;
    logic                       r_pred_head;
    logic [IW-1:0]              r_nxt;
    logic [IW-1:0]              r_slot;
    logic                       r_from_list;

    // result registers
    logic [sll_pkg::STATUS_W-1:0]  r_res_status;
    logic [DATA_WIDTH-1:0]         r_res_dout;
    logic [sll_pkg::STATUS_W-1:0]  r_out_status;
    logic [sll_pkg::M_TDATA_W-1:0] r_out_data;

    // ram ports
    logic                  w_link_we;
    logic [IW-1:0]         w_link_waddr;
    logic [IW-1:0]         w_link_wdata;
    logic [IW-1:0]         w_link_raddr;
    logic [IW-1:0]         w_link_rd;
    logic                  w_data_we;
    logic [DATA_WIDTH-1:0] w_data_rd;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_out_busy;
    logic [IW-1:0]         w_node_idx;
    logic [63:0]           w_value_ext;
    logic [63:0]           w_dout_ext;

    assign w_accept    = (i_ctrl.uop == sll_pkg::U_IDLE) && i_in_valid;
    assign o_in_ready  = (i_ctrl.uop == sll_pkg::U_IDLE);
    assign w_node_idx  = IW'(r_node_raw);
    assign w_full      = (r_free_head == '0) && (r_fill == FW'(ENTRIES));
    assign w_out_busy  = r_out_valid && !i_out_ready;
    assign w_value_ext = 64'(i_value);
    assign w_dout_ext  = 64'(r_res_dout);

    // status toward the sequencer
    always_comb begin
        o_flags.req       = i_in_valid;
        o_flags.op_ins    = (r_op == sll_pkg::OP_INSERT);
        o_flags.op_notake = !((r_op == sll_pkg::OP_TAKE_IDX) || (r_op == sll_pkg::OP_TAKE_TAIL));
        o_flags.bad       = (r_used_head == '0) || (!r_tail_mode &&
                            ((r_node_raw == 6'd1) || (32'(r_node_raw) >= 32'(ENTRIES))));
        o_flags.head_hit  = !r_tail_mode && (r_used_head == w_node_idx);
        o_flags.more      = (w_link_rd != '0) && (r_tail_mode || (w_link_rd != w_node_idx));
        o_flags.not_found = !r_tail_mode && (r_nxt == '0);
        o_flags.full      = w_full;
        o_flags.head_zero = (r_used_head == '0);
        o_flags.out_busy  = w_out_busy;
    end

    // link read address
    always_comb begin
        case (i_ctrl.uop)
            sll_pkg::U_START: w_link_raddr = r_used_head;
            sll_pkg::U_WALK:  w_link_raddr = w_link_rd;
            sll_pkg::U_ALLOC: w_link_raddr = r_free_head;
            default:          w_link_raddr = r_slot;
        endcase
    end

    // link write port
    always_comb begin
        w_link_we    = 1'b0;
        w_link_waddr = r_slot;
        w_link_wdata = '0;
        case (i_ctrl.uop)
            sll_pkg::U_POP: begin
                w_link_we = 1'b1;
            end
            sll_pkg::U_UNLINK: begin
                w_link_we    = !r_pred_head;
                w_link_waddr = r_pred;
                w_link_wdata = w_link_rd;
            end
            sll_pkg::U_RELEASE: begin
                w_link_we    = 1'b1;
                w_link_wdata = r_free_head;
            end
            sll_pkg::U_APPEND: begin
                w_link_we    = 1'b1;
                w_link_waddr = r_cur;
                w_link_wdata = r_slot;
            end
            default: begin
                w_link_we = 1'b0;
            end
        endcase
    end

    assign w_data_we = (i_ctrl.uop == sll_pkg::U_POP);

    sll_ram #(
        .WIDTH (IW),
        .DEPTH (ENTRIES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (w_link_waddr),
        .i_wdata (w_link_wdata),
        .i_raddr (w_link_raddr),
        .o_rdata (w_link_rd)
    );

    sll_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (ENTRIES)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_data_we),
        .i_waddr (r_slot),
        .i_wdata (r_value),
        .i_raddr (r_slot),
        .o_rdata (w_data_rd)
    );

    // chain heads and fresh-entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_used_head <= '0;
            r_fill      <= FW'(2);
        end else begin
            case (i_ctrl.uop)
                sll_pkg::U_ALLOC: begin
                    if (!w_full && (r_free_head == '0)) begin
                        r_fill <= FW'(r_fill + 1'b1);
                    end
                end
                sll_pkg::U_POP: begin
                    if (r_from_list) begin
                        r_free_head <= w_link_rd;
                    end
                end
                sll_pkg::U_UNLINK: begin
                    if (r_pred_head) begin
                        r_used_head <= w_link_rd;
                    end
                end
                sll_pkg::U_RELEASE: r_free_head <= r_slot;
                sll_pkg::U_SETHEAD: r_used_head <= r_slot;
                default: ;
            endcase
        end
    end

    // request latch, walk and result registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op        <= i_op;
            r_node_raw  <= i_node;
            r_value     <= w_value_ext[DATA_WIDTH-1:0];
            r_tail_mode <= (i_op == sll_pkg::OP_INSERT) || (i_op == sll_pkg::OP_TAKE_TAIL) ||
                           ((i_op == sll_pkg::OP_TAKE_IDX) && (i_node == '0));
        end
        case (i_ctrl.uop)
            sll_pkg::U_START: begin
                r_cur       <= r_used_head;
                r_pred_head <= 1'b1;
            end
            sll_pkg::U_WALK: begin
                r_nxt <= w_link_rd;
                if (o_flags.more) begin
                    r_pred      <= r_cur;
                    r_pred_head <= 1'b0;
                    r_cur       <= w_link_rd;
                end
            end
            sll_pkg::U_PICK: begin
                if (r_tail_mode) begin
                    r_slot <= r_cur;
                end else begin
                    r_slot      <= w_node_idx;
                    r_pred      <= r_cur;
                    r_pred_head <= 1'b0;
                end
            end
            sll_pkg::U_HIT: r_slot <= w_node_idx;
            sll_pkg::U_ALLOC: begin
                r_from_list <= (r_free_head != '0);
                r_slot      <= (r_free_head != '0) ? r_free_head : r_fill[IW-1:0];
            end
            sll_pkg::U_UNLINK: r_res_dout <= w_data_rd;
            sll_pkg::U_RELEASE: r_res_status <= sll_pkg::ST_OK;
            sll_pkg::U_RES_OK: begin
                r_res_status <= sll_pkg::ST_OK;
                r_res_dout   <= '0;
            end
            sll_pkg::U_RES_FULL: begin
                r_res_status <= sll_pkg::ST_FULL;
                r_res_dout   <= '0;
            end
            sll_pkg::U_RES_BAD: begin
                r_res_status <= sll_pkg::ST_EMPTY_BAD;
                r_res_dout   <= '0;
            end
            sll_pkg::U_RES_NF: begin
                r_res_status <= sll_pkg::ST_NOT_FOUND;
                r_res_dout   <= '0;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_ctrl.uop == sll_pkg::U_EMIT) && !w_out_busy) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_ctrl.uop == sll_pkg::U_EMIT) && !w_out_busy) begin
            r_out_status <= r_res_status;
            r_out_data   <= w_dout_ext[sll_pkg::M_TDATA_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_data      = r_out_data;

    // fresh-entry count never runs past the table
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(ENTRIES))
        else $error("fresh-entry count beyond table size");

    // allocated entry is never a chain head slot
    a_alloc_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.uop == sll_pkg::U_POP) |-> (r_slot >= IW'(2)))
        else $error("allocated entry is a head slot");

    // chain heads never point at the used head slot
    a_heads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used_head != IW'(1)) && (r_free_head != IW'(1)))
        else $error("chain head points at slot one");

    // a result is only loaded into a free output register
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_ctrl.uop == sll_pkg::U_EMIT) && !w_out_busy) |=> r_out_valid)
        else $error("result not presented after emit");

endmodule
`default_nettype wire

// ===== hw/rtl/static_linked_list_table.sv =====
`default_nettype none
// One request at a time: a new request is accepted only after the result of the last one
// is loaded into the output register; a take or an insert walks the used chain, which
// holds at most ENTRIES - 2 entries, and an output stall holds the table until it clears.
// Reset (synchronous, active low) clears both chain heads and sets the fresh count to 2.
// ----------------------------------------------------------------------------
// static_linked_list_table
// Table of entries threaded into a free chain and a used chain; inserts append
// to the used chain, takes remove the tail or a named entry and free it.
// ----------------------------------------------------------------------------
module static_linked_list_table #(
    parameter int ENTRIES    = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sll_pkg::S_TDATA_W-1:0]     s_tdata,  // node_index, data_value, zero pad
    input  wire logic [sll_pkg::OP_W-1:0]          s_tuser,  // operation
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [sll_pkg::M_TDATA_W-1:0]     m_tdata,  // data_out
    output logic      [sll_pkg::STATUS_W-1:0]      m_tuser   // status
);

    sll_pkg::t_ctrl  w_ctrl;
    sll_pkg::t_flags w_flags;

    // sequencer
    sll_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    // datapath
    sll_dpath #(
        .ENTRIES    (ENTRIES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_flags     (w_flags),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .i_op        (s_tuser),
        .i_node      (s_tdata[sll_pkg::NODE_W-1:0]),
        .i_value     (s_tdata[sll_pkg::NODE_W +: sll_pkg::VALUE_W]),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_status    (m_tuser),
        .o_data      (m_tdata)
    );

endmodule
`default_nettype wire

// ===== test/tb_static_linked_list_table.sv =====
// ----------------------------------------------------------------------------
// tb_static_linked_list_table
// Self-checking bench for the linked list table: a tracker class mirrors the
// free and used chains, predicts status and data for each accepted request
// and compares them in order against the result stream, under random gaps.
// ----------------------------------------------------------------------------
module tb_static_linked_list_table;

    import sll_pkg::*;

    localparam int ENTRIES     = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int RANDOM_REQS = 1030;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 120;
    localparam int MAX_SHOWN   = 10;

    // operation code the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // stimulus shapes for the random part
    typedef enum int { MODE_FILL, MODE_DRAIN, MODE_MIXED } t_mode;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [VALUE_W-1:0]   data_out;
    } t_result;

    // mirror of both chains plus the results still to arrive
    class list_table_tracker;
        logic [NODE_W-1:0]     link_q[ENTRIES];
        logic [DATA_WIDTH-1:0] word_q[ENTRIES];
        t_result               awaited_results[$];
        int                    mismatches;
        int                    status_seen[4];
        int                    requests;
        int                    peak_used;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                link_q[i] = (i + 1 < ENTRIES) ? NODE_W'(i + 1) : '0;
                word_q[i] = '0;
            end
            link_q[0] = link_q[1];
            link_q[1] = '0;
            mismatches = 0;
            requests = 0;
            peak_used = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // walk the used chain; ends on the tail and its predecessor
        function void find_tail(output logic [NODE_W-1:0] tail,
                                output logic [NODE_W-1:0] pred);
            int steps;
            tail = 1;
            pred = 1;
            steps = 0;
            while (link_q[tail] != 0 && steps < ENTRIES) begin
                pred = tail;
                tail = link_q[tail];
                steps++;
            end
        endfunction

        function int used_count();
            logic [NODE_W-1:0] cur;
            int n;
            cur = 1;
            n = 0;
            while (link_q[cur] != 0 && n < ENTRIES) begin
                cur = link_q[cur];
                n++;
            end
            return n;
        endfunction

        function logic [NODE_W-1:0] used_slot(input int pos);
            logic [NODE_W-1:0] cur;
            cur = link_q[1];
            for (int k = 0; k < pos; k++) cur = link_q[cur];
            return cur;
        endfunction

        function void release_slot(input logic [NODE_W-1:0] slot);
            link_q[slot] = link_q[0];
            link_q[0] = slot;
        endfunction

        // advance the mirror by one request and give its result
        function t_result apply_request(input logic [OP_W-1:0]    op,
                                        input logic [NODE_W-1:0]  node,
                                        input logic [VALUE_W-1:0] value);
            t_result           res;
            logic [NODE_W-1:0] slot, tail, pred, idx, cur;
            logic              found;
            int                steps;
            res.status = ST_OK;
            res.data_out = '0;
            case (op)
                OP_INSERT: begin
                    slot = link_q[0];
                    if (slot == 0 || slot == 1) begin
                        res.status = ST_FULL;
                    end else begin
                        word_q[slot] = value[DATA_WIDTH-1:0];
                        link_q[0] = link_q[slot];
                        link_q[slot] = '0;
                        find_tail(tail, pred);
                        link_q[tail] = slot;
                    end
                end
                OP_TAKE_IDX, OP_TAKE_TAIL: begin
                    idx = (op == OP_TAKE_TAIL) ? '0 : node;
                    // index range is exactly the table, so only slot one is bad
                    if (link_q[1] == 0 || idx == 1) begin
                        res.status = ST_EMPTY_BAD;
                    end else if (idx == 0) begin
                        find_tail(tail, pred);
                        res.data_out = VALUE_W'(word_q[tail]);
                        word_q[tail] = '0;
                        link_q[pred] = '0;
                        release_slot(tail);
                    end else begin
                        cur = 1;
                        found = 1'b0;
                        steps = 0;
                        while (!found && link_q[cur] != 0 && steps < ENTRIES) begin
                            if (link_q[cur] == idx) begin
                                found = 1'b1;
                            end else begin
                                cur = link_q[cur];
                                steps++;
                            end
                        end
                        if (!found) begin
                            res.status = ST_NOT_FOUND;
                        end else begin
                            link_q[cur] = link_q[idx];
                            res.data_out = VALUE_W'(word_q[idx]);
                            word_q[idx] = '0;
                            release_slot(idx);
                        end
                    end
                end
                default: ;
            endcase
            return res;
        endfunction

        function void note_request(input logic [OP_W-1:0]    op,
                                   input logic [NODE_W-1:0]  node,
                                   input logic [VALUE_W-1:0] value);
            t_result res;
            int      n;
            res = apply_request(op, node, value);
            awaited_results.push_back(res);
            status_seen[res.status]++;
            requests++;
            n = used_count();
            if (n > peak_used) peak_used = n;
        endfunction

        function void check_result(input logic [STATUS_W-1:0] status,
                                   input logic [VALUE_W-1:0]  data_out);
            t_result exp_res;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result: status %0d data %h", status, data_out);
                return;
            end
            exp_res = awaited_results.pop_front();
            if (status !== exp_res.status) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("status mismatch: expected %0d got %0d",
                             exp_res.status, status);
            end
            if (data_out !== exp_res.data_out) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("data mismatch: expected %h got %h",
                             exp_res.data_out, data_out);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // node_index, data_value, zero pad
    logic [OP_W-1:0]       s_tuser;   // operation
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // data_out
    logic [STATUS_W-1:0]   m_tuser;   // status

    list_table_tracker tracker;
    logic              sender_idles;
    logic              receiver_idles;
    int                cycle_count = 0;

    static_linked_list_table #(
        .ENTRIES    (ENTRIES),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one request: optional gap, then hold until accepted
    task automatic send_request(input logic [OP_W-1:0]    op,
                                input logic [NODE_W-1:0]  node,
                                input logic [VALUE_W-1:0] value);
        int gap;
        gap = sender_idles ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, value, node};
        do @(posedge i_clk); while (!s_tready);
        tracker.note_request(op, node, value);
    endtask

    // take by index aimed at a live entry when there is one
    task automatic take_live_entry();
        int n;
        n = tracker.used_count();
        if (n > 0)
            send_request(OP_TAKE_IDX, tracker.used_slot($urandom_range(0, n - 1)),
                         $urandom());
        else
            send_request(OP_TAKE_IDX, NODE_W'($urandom()), $urandom());
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_request(OP_UNUSED, NODE_W'($urandom()), $urandom());
            1: send_request(OP_TAKE_IDX, 6'd1, $urandom());
            2: send_request(OP_TAKE_IDX, 6'd0, $urandom());
            default: send_request(OP_TAKE_IDX, NODE_W'($urandom()), $urandom());
        endcase
    endtask

    // result side: random stalls, check every accepted result
    initial begin
        int stall;
        int taken;
        m_tready = 1'b0;
        receiver_idles = 1'b1;
        taken = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 32 == 0) receiver_idles = ($urandom_range(0, 3) != 0);
            stall = receiver_idles ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            tracker.check_result(m_tuser, m_tdata);
            taken++;
        end
    end

    // reset, directed requests, random chunks, drain
    initial begin
        t_mode mode;
        int    chunk_left;
        int    r;
        tracker = new();
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_INSERT;
        sender_idles = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list, unused code, field extremes
        send_request(OP_TAKE_TAIL, 6'd0, 32'h0);
        send_request(OP_TAKE_IDX, 6'd5, 32'hffff_ffff);
        send_request(OP_TAKE_IDX, 6'd0, 32'h0);
        send_request(OP_UNUSED, 6'd63, 32'hffff_ffff);
        send_request(OP_INSERT, 6'd0, 32'h0000_0000);
        send_request(OP_INSERT, 6'd63, 32'hffff_ffff);
        send_request(OP_INSERT, 6'd21, 32'ha5a5_a5a5);
        send_request(OP_INSERT, 6'd42, 32'h5a5a_5a5a);
        send_request(OP_INSERT, 6'd7, 32'h8000_0001);
        // bad index, free entry, tail by index zero
        send_request(OP_TAKE_IDX, 6'd1, 32'h0);
        send_request(OP_TAKE_IDX, 6'd63, 32'h0);
        send_request(OP_TAKE_IDX, 6'd0, 32'h0);
        send_request(OP_UNUSED, 6'd0, 32'h0);
        // middle, head, then tail
        send_request(OP_TAKE_IDX, tracker.used_slot(1), 32'h0);
        send_request(OP_TAKE_IDX, tracker.used_slot(0), 32'h0);
        send_request(OP_TAKE_TAIL, 6'd63, 32'hffff_ffff);
        send_request(OP_TAKE_IDX, 6'd2, 32'h0);
        send_request(OP_TAKE_TAIL, 6'd0, 32'h0);
        send_request(OP_TAKE_IDX, 6'd1, 32'h0);
        send_request(OP_INSERT, 6'd0, 32'h1234_5678);
        send_request(OP_TAKE_IDX, tracker.used_slot(0), 32'h0);

        // random part; first chunk fills the table past full
        mode = MODE_FILL;
        chunk_left = 90;
        for (int k = 0; k < RANDOM_REQS; k++) begin
            if (chunk_left == 0) begin
                r = $urandom_range(0, 2);
                mode = (r == 0) ? MODE_FILL : (r == 1) ? MODE_DRAIN : MODE_MIXED;
                chunk_left = $urandom_range(20, 90);
                sender_idles = ($urandom_range(0, 3) != 0);
            end
            chunk_left--;
            r = $urandom_range(0, 99);
            case (mode)
                MODE_FILL: begin
                    if (r < 88)      send_request(OP_INSERT, NODE_W'($urandom()), $urandom());
                    else if (r < 94) take_live_entry();
                    else if (r < 97) send_request(OP_TAKE_TAIL, NODE_W'($urandom()), $urandom());
                    else             send_noise();
                end
                MODE_DRAIN: begin
                    if (r < 15)      send_request(OP_INSERT, NODE_W'($urandom()), $urandom());
                    else if (r < 60) take_live_entry();
                    else if (r < 88) send_request(OP_TAKE_TAIL, NODE_W'($urandom()), $urandom());
                    else             send_noise();
                end
                default: begin
                    if (r < 45)      send_request(OP_INSERT, NODE_W'($urandom()), $urandom());
                    else if (r < 75) take_live_entry();
                    else if (r < 90) send_request(OP_TAKE_TAIL, NODE_W'($urandom()), $urandom());
                    else             send_noise();
                end
            endcase
        end
        s_tvalid <= 1'b0;

        // wait for every result, then some quiet cycles for strays
        while (tracker.awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("run: %0d requests, peak occupancy %0d of %0d entries",
                 tracker.requests, tracker.peak_used, ENTRIES - 2);
        $display("results: ok %0d, full %0d, empty or bad %0d, not found %0d, mismatches %0d",
                 tracker.status_seen[ST_OK], tracker.status_seen[ST_FULL],
                 tracker.status_seen[ST_EMPTY_BAD], tracker.status_seen[ST_NOT_FOUND],
                 tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.awaited_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
